### src/rpe_pkg.sv
package rpe_pkg;

    // Block configuration
    localparam int HEAD_LEN     = 128;
    localparam int THETA        = 1000000;
    localparam int CORDIC_STEPS = 16;

    localparam int TABLE_DEPTH  = 64;
    localparam int MAX_STEPS    = 32;
    localparam int IDX_W        = 6;
    localparam int DATA_W       = 16;
    localparam int PHASE_W      = 32;
    // CORDIC datapath: Q30 values plus guard and sign bits
    localparam int CW           = 34;

    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef logic [PHASE_W-1:0] t_freq_tab [TABLE_DEPTH];
    typedef logic [PHASE_W-1:0] t_angle_tab [MAX_STEPS];

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    typedef struct packed {
        logic signed [DATA_W-1:0] first;
        logic signed [DATA_W-1:0] second;
    } t_pair;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        t_pair              pair;
    } t_cordic_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] cos_q15;
        logic signed [DATA_W-1:0] sin_q15;
        t_pair                    pair;
    } t_cordic_out;

    // Integer square root, bit pair at a time
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = v_in;
        res   = 64'd0;
        bit_w = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bit_w > v) begin
                bit_w = bit_w >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bit_w != 64'd0) begin
                if (v >= res + bit_w) begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
        end
        return res;
    endfunction

    // Restoring shift-subtract quotient, used only while building tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // log2(THETA) in Q32 by repeated squaring
    function automatic logic [63:0] log2_theta_q32();
        logic [63:0] t;
        logic [63:0] y;
        logic [63:0] l;
        int          n;
        t = 64'(THETA);
        l = 64'd0;
        n = 0;
        for (int j = 0; j < 40; j++) begin
            if ((t >> (n + 1)) != 64'd0) begin
                n++;
            end
        end
        y = (t << 30) >> n;
        for (int j = 0; j < 32; j++) begin
            y = (y * y) >> 30;
            l = l << 1;
            if (y >= (64'd1 << 31)) begin
                y = y >> 1;
                l = l | 64'd1;
            end
        end
        return (64'(n) << 32) | l;
    endfunction

    // Per-index rotation rate in turns, unsigned 0.32
    function automatic t_freq_tab build_freq_tab();
        t_freq_tab   tab;
        logic [63:0] rh [33];
        logic [63:0] lg;
        logic [63:0] e;
        logic [63:0] ip;
        logic [63:0] fr;
        logic [63:0] m;
        logic [63:0] r;
        lg    = log2_theta_q32();
        rh[0] = 64'd1 << 31;
        rh[1] = isqrt64((64'd1 << 30) << 31);
        for (int j = 2; j <= 32; j++) begin
            rh[j] = isqrt64(rh[j-1] << 31);
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            e  = (lg * 64'(2 * i)) / 64'(HEAD_LEN);
            ip = e >> 32;
            fr = e & 64'hFFFF_FFFF;
            m  = 64'd1 << 31;
            for (int j = 1; j <= 32; j++) begin
                if (fr[32-j]) begin
                    m = (m * rh[j]) >> 31;
                end
            end
            r = (m * INV_TWO_PI_Q32 + (64'd1 << 30)) >> 31;
            tab[i] = (ip >= 64'd63) ? '0 : PHASE_W'(r >> ip);
        end
        return tab;
    endfunction

    // atan(2^-k) in turns Q32 from an integer arctan series
    function automatic t_angle_tab build_angle_tab();
        t_angle_tab  tab;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] rad;
        tab[0] = PHASE_W'(64'd1 << 29);
        for (int k = 1; k < MAX_STEPS; k++) begin
            sum = 64'd0;
            for (int n = 0; n < 32; n++) begin
                if (k * (2 * n + 1) < 63) begin
                    term = udiv64((64'd1 << 62) >> (k * (2 * n + 1)), 64'(2 * n + 1));
                    if ((n & 1) != 0) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            rad    = (sum + (64'd1 << 29)) >> 30;
            tab[k] = PHASE_W'((rad * INV_TWO_PI_Q32 + (64'd1 << 31)) >> 32);
        end
        return tab;
    endfunction

    localparam t_freq_tab  FREQ_TAB  = build_freq_tab();
    localparam t_angle_tab ANGLE_TAB = build_angle_tab();

    // Round Q30 to Q1.15 and clip to 16 bits
    function automatic logic signed [DATA_W-1:0] round_q30(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767) begin
            return 16'sh7FFF;
        end else if (r < -34'sd32768) begin
            return 16'sh8000;
        end
        return r[DATA_W-1:0];
    endfunction

endpackage

### src/rpe_if.sv
interface rpe_in_if import rpe_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  first_value;
    logic signed [DATA_W-1:0]  second_value;
    logic [IDX_W-1:0]          pair_index;
    logic [DATA_W-1:0]         position;

    modport source (output valid, first_value, second_value, pair_index, position,
                    input ready);
    modport sink   (input valid, first_value, second_value, pair_index, position,
                    output ready);
endinterface

interface rpe_out_if import rpe_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  rotated_first;
    logic signed [DATA_W-1:0]  rotated_second;
    logic                      saturated;

    modport source (output valid, rotated_first, rotated_second, saturated,
                    input ready);
    modport sink   (input valid, rotated_first, rotated_second, saturated,
                    output ready);
endinterface

### src/rpe_cordic.sv
module rpe_cordic import rpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cordic_in  i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cordic_out o_res
);

    // Stage taps: index 0 is the incoming request, k+1 the output of step k
    logic signed [CW-1:0] w_x   [CORDIC_STEPS+1];
    logic signed [CW-1:0] w_y   [CORDIC_STEPS+1];
    logic signed [CW-1:0] w_z   [CORDIC_STEPS+1];
    t_quad                w_q   [CORDIC_STEPS+1];
    t_pair                w_ab  [CORDIC_STEPS+1];
    logic                 w_v   [CORDIC_STEPS+1];
    logic                 w_rdy [CORDIC_STEPS+1];

    // Seed: gain-scaled unit vector, residual angle within the quadrant
    assign w_x[0]  = CORDIC_GAIN_Q30;
    assign w_y[0]  = '0;
    assign w_z[0]  = $signed({{(CW-30){1'b0}}, i_req.phase[29:0]});
    assign w_q[0]  = t_quad'(i_req.phase[PHASE_W-1:PHASE_W-2]);
    assign w_ab[0] = i_req.pair;
    assign w_v[0]  = i_valid;
    assign o_ready = w_rdy[0];

    // One micro-rotation per register stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        localparam logic signed [CW-1:0] ANG = $signed({{(CW-PHASE_W){1'b0}}, ANGLE_TAB[k]});

        logic signed [CW-1:0] n_x, n_y, n_z;
        logic signed [CW-1:0] r_x, r_y, r_z;
        t_quad                r_q;
        t_pair                r_ab;
        logic                 r_v;

        always_comb begin
            if (!w_z[k][CW-1]) begin
                n_x = w_x[k] - (w_y[k] >>> k);
                n_y = w_y[k] + (w_x[k] >>> k);
                n_z = w_z[k] - ANG;
            end else begin
                n_x = w_x[k] + (w_y[k] >>> k);
                n_y = w_y[k] - (w_x[k] >>> k);
                n_z = w_z[k] + ANG;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_x  <= n_x;
                r_y  <= n_y;
                r_z  <= n_z;
                r_q  <= w_q[k];
                r_ab <= w_ab[k];
            end
        end

        assign w_x[k+1]  = r_x;
        assign w_y[k+1]  = r_y;
        assign w_z[k+1]  = r_z;
        assign w_q[k+1]  = r_q;
        assign w_ab[k+1] = r_ab;
        assign w_v[k+1]  = r_v;
        // Advance while the next stage is empty or moving
        assign w_rdy[k]  = !r_v || w_rdy[k+1];
    end

    // Quadrant fold and rounding stage
    logic signed [CW-1:0] n_c, n_s;
    t_cordic_out          r_res;
    logic                 r_mv;

    always_comb begin
        case (w_q[CORDIC_STEPS])
            QUAD_I: begin
                n_c = w_x[CORDIC_STEPS];
                n_s = w_y[CORDIC_STEPS];
            end
            QUAD_II: begin
                n_c = -w_y[CORDIC_STEPS];
                n_s = w_x[CORDIC_STEPS];
            end
            QUAD_III: begin
                n_c = -w_x[CORDIC_STEPS];
                n_s = -w_y[CORDIC_STEPS];
            end
            QUAD_IV: begin
                n_c = w_y[CORDIC_STEPS];
                n_s = -w_x[CORDIC_STEPS];
            end
            default: begin
                n_c = w_x[CORDIC_STEPS];
                n_s = w_y[CORDIC_STEPS];
            end
        endcase
    end

    assign w_rdy[CORDIC_STEPS] = !r_mv || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (w_rdy[CORDIC_STEPS]) begin
            r_mv <= w_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[CORDIC_STEPS]) begin
            r_res.cos_q15 <= round_q30(n_c);
            r_res.sin_q15 <= round_q30(n_s);
            r_res.pair    <= w_ab[CORDIC_STEPS];
        end
    end

    assign o_valid = r_mv;
    assign o_res   = r_res;

endmodule

### src/rotary_position_embedding_top.sv
// Channel   Dir  Fields                                            Handshake
// i_pair    in   first_value, second_value, pair_index, position   valid/ready
// o_pair    out  rotated_first, rotated_second, saturated          valid/ready
//
// Throughput: one pair per cycle while o_pair does not stall; the registered stages
// are the lookup, phase multiply, one CORDIC micro-rotation per stage, quadrant
// fold, the four-product stage and the sum/round/clip stage.
// Reset clears only the stage valid bits; the rate and arctan tables are constants.
// A stall at o_pair holds the full stages from o_pair back to the first empty one;
// stages before that keep filling, so input is taken while a finished result waits.
module rotary_position_embedding_top import rpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpe_in_if.sink     i_pair,
    rpe_out_if.source  o_pair
);

    // Stage A: rate lookup
    logic                     r_va;
    t_pair                    r_a_pair;
    logic [DATA_W-1:0]        r_pos;
    logic [PHASE_W-1:0]       r_rate;
    logic                     rdy_a;

    // Stage B: fractional phase
    logic                     r_vb;
    t_pair                    r_b_pair;
    logic [PHASE_W-1:0]       r_phase;
    logic                     rdy_b;
    logic [DATA_W+PHASE_W-1:0] w_phase_full;

    // CORDIC unit
    logic                     cdc_in_ready;
    logic                     cdc_out_valid;
    t_cordic_in               cdc_req;
    t_cordic_out              cdc_res;

    // Stage D: products
    logic                     r_vd;
    logic signed [2*DATA_W-1:0] r_p_ac, r_p_bs, r_p_bc, r_p_as;
    logic                     rdy_d;

    // Stage E: sums, rounding, clip
    logic                     r_ve;
    logic signed [DATA_W-1:0] r_rf, r_rs;
    logic                     r_sat;
    logic                     rdy_e;
    logic signed [2*DATA_W+1:0] w_sum1, w_sum2, w_sh1, w_sh2;
    logic signed [DATA_W-1:0] n_rf, n_rs;
    logic                     n_sat1, n_sat2;

    // Ready chain: a stage loads when it is empty or its successor advances
    assign rdy_e        = !r_ve || o_pair.ready;
    assign rdy_d        = !r_vd || rdy_e;
    assign rdy_b        = !r_vb || cdc_in_ready;
    assign rdy_a        = !r_va || rdy_b;
    assign i_pair.ready = rdy_a;

    // Look up the per-index rate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (rdy_a) begin
            r_va <= i_pair.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_pair.first  <= i_pair.first_value;
            r_a_pair.second <= i_pair.second_value;
            r_pos           <= i_pair.position;
            r_rate          <= FREQ_TAB[i_pair.pair_index];
        end
    end

    // Phase is position times rate, modulo one turn
    assign w_phase_full = (DATA_W+PHASE_W)'(r_pos) * (DATA_W+PHASE_W)'(r_rate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (rdy_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_pair <= r_a_pair;
            r_phase  <= w_phase_full[PHASE_W-1:0];
        end
    end

    assign cdc_req.phase = r_phase;
    assign cdc_req.pair  = r_b_pair;

    rpe_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vb),
        .o_ready (cdc_in_ready),
        .i_req   (cdc_req),
        .o_valid (cdc_out_valid),
        .i_ready (rdy_d),
        .o_res   (cdc_res)
    );

    // Form the four cross products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (rdy_d) begin
            r_vd <= cdc_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_d) begin
            r_p_ac <= (2*DATA_W)'(cdc_res.pair.first)  * (2*DATA_W)'(cdc_res.cos_q15);
            r_p_bs <= (2*DATA_W)'(cdc_res.pair.second) * (2*DATA_W)'(cdc_res.sin_q15);
            r_p_bc <= (2*DATA_W)'(cdc_res.pair.second) * (2*DATA_W)'(cdc_res.cos_q15);
            r_p_as <= (2*DATA_W)'(cdc_res.pair.first)  * (2*DATA_W)'(cdc_res.sin_q15);
        end
    end

    // Combine, round to nearest and saturate
    always_comb begin
        w_sum1 = (2*DATA_W+2)'(r_p_ac) - (2*DATA_W+2)'(r_p_bs) + 34'sd16384;
        w_sum2 = (2*DATA_W+2)'(r_p_bc) + (2*DATA_W+2)'(r_p_as) + 34'sd16384;
        w_sh1  = w_sum1 >>> 15;
        w_sh2  = w_sum2 >>> 15;
        n_sat1 = 1'b1;
        n_sat2 = 1'b1;
        if (w_sh1 > 34'sd32767) begin
            n_rf = 16'sh7FFF;
        end else if (w_sh1 < -34'sd32768) begin
            n_rf = 16'sh8000;
        end else begin
            n_rf   = w_sh1[DATA_W-1:0];
            n_sat1 = 1'b0;
        end
        if (w_sh2 > 34'sd32767) begin
            n_rs = 16'sh7FFF;
        end else if (w_sh2 < -34'sd32768) begin
            n_rs = 16'sh8000;
        end else begin
            n_rs   = w_sh2[DATA_W-1:0];
            n_sat2 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (rdy_e) begin
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_e) begin
            r_rf  <= n_rf;
            r_rs  <= n_rs;
            r_sat <= n_sat1 || n_sat2;
        end
    end

    assign o_pair.valid          = r_ve;
    assign o_pair.rotated_first  = r_rf;
    assign o_pair.rotated_second = r_rs;
    assign o_pair.saturated      = r_sat;

`ifndef NO_ASSERTIONS
    // Input back-pressure only when both front stages are occupied
    a_front_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pair.ready |-> (r_va && r_vb))
        else $error("input stalled with an empty front stage");

    // A flagged result sits on a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ve && r_sat) |-> (r_rf == 16'sh7FFF || r_rf == 16'sh8000 ||
                             r_rs == 16'sh7FFF || r_rs == 16'sh8000))
        else $error("saturation flag without a clipped output");

    // A held product stage keeps its products
    a_prod_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vd && !rdy_d) |=> ($stable(r_p_ac) && $stable(r_p_bs) &&
                             $stable(r_p_bc) && $stable(r_p_as) && r_vd))
        else $error("stalled product stage changed");
`endif

endmodule

### verif/rotary_position_embedding_top_tb.sv
module rotary_position_embedding_top_tb;
    import rpe_pkg::*;

    localparam int NUM_RANDOM  = 1250;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = CORDIC_STEPS + 5 + 8;

    typedef struct {
        logic signed [DATA_W-1:0] first;
        logic signed [DATA_W-1:0] second;
        logic [IDX_W-1:0]         idx;
        logic [DATA_W-1:0]        pos;
        int unsigned              gap;
    } t_pair_req;

    typedef struct {
        logic signed [DATA_W-1:0] rot_first;
        logic signed [DATA_W-1:0] rot_second;
        logic                     sat;
    } t_rot_result;

    logic i_clk;
    logic i_rst_n;

    rpe_in_if  req_if ();
    rpe_out_if res_if ();

    rotary_position_embedding_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (req_if),
        .o_pair  (res_if)
    );

    // Own copy of the rate and arctan tables
    logic [PHASE_W-1:0] rate_tab [TABLE_DEPTH];
    logic [PHASE_W-1:0] arc_tab [MAX_STEPS];

    t_pair_req   pending_pairs[$];
    t_rot_result pending_rotations[$];

    bit          send_burst;
    bit          req_taken;
    bit          res_taken;
    int unsigned send_wait;
    int unsigned sink_wait;
    int unsigned idle_cycles;
    int unsigned fail_count;
    int unsigned pairs_taken;
    int unsigned pairs_checked;
    int unsigned sat_seen;
    logic [TABLE_DEPTH-1:0] idx_seen;

    // Clock
    initial begin
        i_clk = 1'b0;
    end
    always begin
        #6 i_clk = ~i_clk;
    end

    // Round a Q30 value to Q1.15, clipped to 16 bits
    function automatic longint round_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return r;
    endfunction

    // Clip to 16 bits and note whether clipping happened
    function automatic logic signed [DATA_W-1:0] sat16(input longint v, inout bit clipped);
        if (v > 32767) begin
            clipped = 1'b1;
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            clipped = 1'b1;
            return 16'sh8000;
        end
        return DATA_W'(v);
    endfunction

    // Rotate one pair by position times the per-index rate
    function automatic t_rot_result predict_rotation(input logic signed [DATA_W-1:0] a_in,
                                                     input logic signed [DATA_W-1:0] b_in,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [DATA_W-1:0] pos);
        logic [PHASE_W-1:0] phase;
        t_quad              quad;
        longint             x;
        longint             y;
        longint             z;
        longint             dx;
        longint             dy;
        longint             c;
        longint             s;
        longint             a;
        longint             b;
        bit                 clipped;
        t_rot_result        r;
        phase   = PHASE_W'(64'(pos) * 64'(rate_tab[idx]));
        quad    = t_quad'(phase[31:30]);
        x       = longint'(CORDIC_GAIN_Q30);
        y       = 0;
        z       = longint'(phase[29:0]);
        a       = longint'(a_in);
        b       = longint'(b_in);
        clipped = 1'b0;
        for (int k = 0; k < CORDIC_STEPS && k < MAX_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(arc_tab[k]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(arc_tab[k]);
            end
        end
        // Fold the first-quadrant result out to the full circle
        case (quad)
            QUAD_I: begin
                c = x;
                s = y;
            end
            QUAD_II: begin
                c = -y;
                s = x;
            end
            QUAD_III: begin
                c = -x;
                s = -y;
            end
            default: begin
                c = y;
                s = -x;
            end
        endcase
        c = round_q15(c);
        s = round_q15(s);
        r.rot_first  = sat16((a * c - b * s + 64'sd16384) >>> 15, clipped);
        r.rot_second = sat16((b * c + a * s + 64'sd16384) >>> 15, clipped);
        r.sat        = clipped;
        return r;
    endfunction

    // Build rate table (turns per position) and arctan step angles
    initial begin : build_rate_tables
        logic [63:0] root_half [33];
        logic [63:0] t;
        logic [63:0] y;
        logic [63:0] lg;
        logic [63:0] v;
        logic [63:0] root;
        logic [63:0] cand;
        logic [63:0] e;
        logic [63:0] ip;
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] rad;
        int          n_bits;

        // log2(THETA) in Q32: integer part from the top bit, fraction by squaring
        t      = 64'(THETA);
        n_bits = 0;
        while (n_bits < 40 && (t >> (n_bits + 1)) != 64'd0) begin
            n_bits++;
        end
        y  = (t << 30) >> n_bits;
        lg = 64'd0;
        for (int j = 0; j < 32; j++) begin
            y  = (y * y) >> 30;
            lg = lg << 1;
            if (y >= (64'd1 << 31)) begin
                y  = y >> 1;
                lg = lg | 64'd1;
            end
        end
        lg = (64'(n_bits) << 32) | lg;

        // Successive square roots of one half, Q31
        root_half[0] = 64'd1 << 31;
        for (int j = 1; j <= 32; j++) begin
            v    = (j == 1) ? ((64'd1 << 30) << 31) : (root_half[j-1] << 31);
            root = 64'd0;
            for (int bt = 31; bt >= 0; bt--) begin
                cand = root | (64'd1 << bt);
                if (cand * cand <= v) begin
                    root = cand;
                end
            end
            root_half[j] = root;
        end

        for (int i = 0; i < TABLE_DEPTH; i++) begin
            e  = (lg * 64'(2 * i)) / 64'(HEAD_LEN);
            ip = e >> 32;
            m  = 64'd1 << 31;
            for (int j = 1; j <= 32; j++) begin
                if (e[32-j]) begin
                    m = (m * root_half[j]) >> 31;
                end
            end
            r = (m * INV_TWO_PI_Q32 + (64'd1 << 30)) >> 31;
            rate_tab[i] = (ip >= 64'd63) ? '0 : PHASE_W'(r >> ip);
        end

        // atan(2^-k) from the odd power series, then radians to turns
        arc_tab[0] = PHASE_W'(64'd1 << 29);
        for (int k = 1; k < MAX_STEPS; k++) begin
            sum = 64'd0;
            for (int n = 0; k * (2 * n + 1) < 63; n++) begin
                term = ((64'd1 << 62) >> (k * (2 * n + 1))) / 64'(2 * n + 1);
                if ((n % 2) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            rad        = (sum + (64'd1 << 29)) >> 30;
            arc_tab[k] = PHASE_W'((rad * INV_TWO_PI_Q32 + (64'd1 << 31)) >> 32);
        end
    end

    // Queue one request with its lead-in gap
    task automatic queue_pair(input logic signed [DATA_W-1:0] a,
                              input logic signed [DATA_W-1:0] b,
                              input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] pos);
        t_pair_req p;
        p.first  = a;
        p.second = b;
        p.idx    = idx;
        p.pos    = pos;
        p.gap    = send_burst ? 0 : $urandom_range(0, 6);
        pending_pairs.push_back(p);
    endtask

    // Element value: mostly uniform, some extremes, some small
    function automatic logic signed [DATA_W-1:0] draw_element();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return DATA_W'($urandom);
        end
        if (sel < 8) begin
            case ($urandom_range(0, 4))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sh8001;
                3: return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        return DATA_W'($urandom_range(0, 511)) - 16'sd256;
    endfunction

    // Stimulus and end of run
    initial begin : stimulus
        logic [DATA_W-1:0] pos;
        int unsigned       sel;

        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.first_value  = '0;
        req_if.second_value = '0;
        req_if.pair_index   = '0;
        req_if.position     = '0;
        res_if.ready        = 1'b0;
        req_taken           = 1'b0;
        res_taken           = 1'b0;
        send_wait           = 0;
        sink_wait           = 0;
        idle_cycles         = 0;
        fail_count          = 0;
        pairs_taken         = 0;
        pairs_checked       = 0;
        sat_seen            = 0;
        idx_seen            = '0;
        send_burst          = 1'b0;

        // Directed: extremes, each quadrant, saturation, phase wrap, slowest rate
        queue_pair(16'sh7FFF, 16'sh7FFF, 6'd0, 16'd0);
        queue_pair(16'sh8000, 16'sh8000, 6'd0, 16'd0);
        queue_pair(16'sh8000, 16'sh0000, 6'd0, 16'd0);
        queue_pair(16'sh0000, 16'sh0000, 6'd0, 16'hFFFF);
        queue_pair(16'sh8000, 16'sh7FFF, 6'd63, 16'hFFFF);
        queue_pair(16'sh7FFF, 16'sh8000, 6'd63, 16'd0);
        queue_pair(16'sh7FFF, 16'sh8000, 6'd0, 16'd1);
        queue_pair(16'sh8000, 16'sh8000, 6'd0, 16'd1);
        queue_pair(16'sh7FFF, 16'sh7FFF, 6'd0, 16'd6);
        queue_pair(16'sh4000, 16'sh0000, 6'd0, 16'd1);
        queue_pair(16'sh4000, 16'sh0000, 6'd0, 16'd2);
        queue_pair(16'sh4000, 16'sh0000, 6'd0, 16'd4);
        queue_pair(16'sh4000, 16'sh0000, 6'd0, 16'd5);
        queue_pair(16'sh0000, 16'sh4000, 6'd0, 16'd3);
        queue_pair(16'sh0001, 16'shFFFF, 6'd0, 16'd3);
        queue_pair(16'sh1234, 16'shEDCC, 6'd0, 16'hFFFF);
        queue_pair(16'sh2000, 16'sh6000, 6'd1, 16'd40000);
        queue_pair(16'sh7FFF, 16'sh0000, 6'd32, 16'h8000);
        queue_pair(16'sh0000, 16'sh7FFF, 6'd63, 16'h7FFF);
        queue_pair(16'shAAAA, 16'sh5555, 6'd42, 16'hAAAA);
        queue_pair(16'sh5555, 16'shAAAA, 6'd21, 16'h5555);

        // Random pairs, with no-gap bursts mixed in
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 80 == 0) begin
                send_burst = ($urandom_range(0, 3) == 0);
            end
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                pos = DATA_W'($urandom);
            end else if (sel < 8) begin
                pos = DATA_W'($urandom_range(0, 255));
            end else begin
                pos = ($urandom_range(0, 1) == 1) ? 16'hFFFF : (16'h8000 | DATA_W'($urandom));
            end
            queue_pair(draw_element(), draw_element(), IDX_W'($urandom_range(0, 63)), pos);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain input side, then results, then let the pipeline settle
        while (pending_pairs.size() != 0 || req_if.valid) begin
            @(posedge i_clk);
        end
        while (pending_rotations.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Rotated %0d pairs over %0d of %0d pair indexes; %0d results saturated.",
                 pairs_checked, $countones(idx_seen), TABLE_DEPTH, sat_seen);
        $display("Source gaps and sink stalls of 0..6 cycles, with gap-free bursts.");
        if (fail_count == 0 && pending_rotations.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Request driver: hold until taken, then wait out the gap and present the next
    always @(negedge i_clk) begin : drive_requests
        t_pair_req nxt;
        logic      hold;
        hold = req_if.valid && !req_taken;
        if (req_taken) begin
            req_taken = 1'b0;
            if (pending_pairs.size() > 0) begin
                send_wait = pending_pairs[0].gap;
            end
        end
        if (!i_rst_n || hold) begin
            // keep the current request on the bus
        end else if (send_wait == 0 && pending_pairs.size() > 0) begin
            nxt = pending_pairs.pop_front();
            req_if.valid        <= 1'b1;
            req_if.first_value  <= nxt.first;
            req_if.second_value <= nxt.second;
            req_if.pair_index   <= nxt.idx;
            req_if.position     <= nxt.pos;
        end else begin
            if (send_wait > 0) begin
                send_wait--;
            end
            req_if.valid        <= 1'b0;
            req_if.first_value  <= DATA_W'($urandom);
            req_if.second_value <= DATA_W'($urandom);
            req_if.pair_index   <= IDX_W'($urandom);
            req_if.position     <= DATA_W'($urandom);
        end
    end

    // Result sink: stall a random number of cycles per result, with no stalls in every third run of 150 results
    always @(negedge i_clk) begin : drive_ready
        if (res_taken) begin
            res_taken = 1'b0;
            sink_wait = ((pairs_checked / 150) % 3 == 2) ? 0 : $urandom_range(0, 6);
        end
        res_if.ready <= i_rst_n && (sink_wait == 0);
        if (res_if.valid && sink_wait > 0) begin
            sink_wait--;
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin : check_rotations
        t_rot_result want;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            pending_rotations.push_back(predict_rotation(req_if.first_value,
                                                         req_if.second_value,
                                                         req_if.pair_index,
                                                         req_if.position));
            idx_seen[req_if.pair_index] = 1'b1;
            pairs_taken++;
            req_taken = 1'b1;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            res_taken = 1'b1;
            pairs_checked++;
            if (res_if.saturated === 1'b1) begin
                sat_seen++;
            end
            if (pending_rotations.size() == 0) begin
                $error("rotated pair with no request outstanding: first %0d second %0d",
                       res_if.rotated_first, res_if.rotated_second);
                fail_count++;
            end else begin
                want = pending_rotations.pop_front();
                if (res_if.rotated_first !== want.rot_first) begin
                    $error("rotated_first: expected %0d, got %0d",
                           want.rot_first, res_if.rotated_first);
                    fail_count++;
                end
                if (res_if.rotated_second !== want.rot_second) begin
                    $error("rotated_second: expected %0d, got %0d",
                           want.rot_second, res_if.rotated_second);
                    fail_count++;
                end
                if (res_if.saturated !== want.sat) begin
                    $error("saturated: expected %0b, got %0b", want.sat, res_if.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: abort when no request or result moves for too long
    always @(posedge i_clk) begin : watchdog
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_rotations.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

### sim.f
src/rpe_pkg.sv
src/rpe_if.sv
src/rpe_cordic.sv
src/rotary_position_embedding_top.sv
verif/rotary_position_embedding_top_tb.sv
